// File: rtl/bffa_pkg.sv
// Shared constants for the bitmap first-fit page allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package bffa_pkg;
  localparam int WORD_W      = 32;   // bitmap bits held by one cell
  localparam int IDX_W       = 5;    // bit index inside a cell word
  localparam int REQ_W       = 13;
  localparam int START_W     = 12;
  localparam int BASE_W      = 40;
  localparam int PAGES_W     = 25;
  localparam int ADDR_W      = 41;
  localparam int STATUS_W    = 2;
  localparam int HDR_SHIFT   = 15;   // 32768 map bits per header page

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd2;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_PAGES = 1'b1;
endpackage
`default_nettype wire

// File: rtl/bffa_cell.sv
// One cell of the bitmap ring: holds one word of the used-page map.
// Depends on bffa_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none
module bffa_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          shift_en,
  input  wire [bffa_pkg::WORD_W-1:0]   d_i,
  output logic [bffa_pkg::WORD_W-1:0]  q_o
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (shift_en) begin
      word_r <= d_i;
    end
  end

  assign q_o = word_r;
endmodule
`default_nettype wire

// File: rtl/bffa_scan.sv
// Head of the bitmap ring: marks bits of the passing word and tracks the free run.
// Depends on bffa_pkg for word and request widths.
`timescale 1ns / 1ps
`default_nettype none
module bffa_scan #(
  parameter int CAP = 4096,
  parameter int CW  = 14
) (
  input  wire [bffa_pkg::WORD_W-1:0]  word_i,
  input  wire [CW-1:0]                base_pos,
  input  wire                         mark_en,
  input  wire [CW-1:0]                mark_lo,
  input  wire [CW-1:0]                mark_hi,
  input  wire                         scan_en,
  input  wire [bffa_pkg::REQ_W-1:0]   run_i,
  input  wire [bffa_pkg::REQ_W-1:0]   req,
  input  wire [CW-1:0]                end_lim,
  output logic [bffa_pkg::WORD_W-1:0] word_o,
  output logic [bffa_pkg::REQ_W-1:0]  run_o,
  output logic                        hit_o,
  output logic [bffa_pkg::IDX_W-1:0]  hit_idx
);
  import bffa_pkg::*;

  localparam logic [CW-1:0] CAP_C = CW'(CAP);

  logic [REQ_W-1:0] run_b [WORD_W];
  logic [WORD_W-1:0] hit_b;

  always_comb begin
    logic [CW-1:0]   pos;
    logic [REQ_W:0]  sum;
    for (int j = 0; j < WORD_W; j++) begin
      pos = base_pos + CW'(j);
      word_o[j] = word_i[j] |
                  (mark_en && pos >= mark_lo && pos < mark_hi && pos < CAP_C);
      // free run ending at this bit: carry in unless a used bit sits at or below it
      sum = {1'b0, run_i} + (REQ_W+1)'(j + 1);
      run_b[j] = sum[REQ_W] ? {REQ_W{1'b1}} : sum[REQ_W-1:0];
      for (int k = 0; k <= j; k++) begin
        if (word_i[k]) run_b[j] = REQ_W'(j - k);
      end
      hit_b[j] = scan_en && (run_b[j] >= req) && (pos < end_lim);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_b[j]) hit_idx = IDX_W'(j);
    end
  end

  assign hit_o = |hit_b;
  assign run_o = run_b[WORD_W-1];
endmodule
`default_nettype wire

// File: rtl/bffa_pkg_unused_guard.sv
// Generic one-word output holding register for the allocator result channel.
// Depends on bffa_pkg for status and address widths.
`timescale 1ns / 1ps
`default_nettype none
module bffa_out_reg (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           load,
  input  wire [bffa_pkg::STATUS_W-1:0]  status_i,
  input  wire [bffa_pkg::ADDR_W-1:0]    addr_i,
  input  wire                           ready_i,
  output logic                          valid_o,
  output logic                          free_o,
  output logic [bffa_pkg::STATUS_W-1:0] status_o,
  output logic [bffa_pkg::ADDR_W-1:0]   addr_o
);
  import bffa_pkg::*;

  logic                valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   addr_r;

  assign free_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (ready_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_i;
      addr_r   <= addr_i;
    end
  end

  assign valid_o  = valid_r;
  assign status_o = status_r;
  assign addr_o   = addr_r;
endmodule
`default_nettype wire

// File: rtl/bitmap_first_fit_page_allocator.sv
// Bitmap first-fit page allocator: a ring of word cells rotates past a scan head.
// Mark: a ring rotation sets the requested bits. Allocate: a scan rotation, a check step
// and a marking rotation, or only the scan and check when nothing fits; zero skips the ring.
// One item at a time; the ring rotation sets the rate. A finished result waits in
// the output register while the next beat is taken.
// Synchronous active-low reset clears the whole map (all pages free), state and config.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_first_fit_page_allocator #(
  parameter int PAGE_CAPACITY = 4096
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [11:0] start_page, [24:12] request_pages, rest zero
  input  wire  [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // [40:0] address_page, rest zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import bffa_pkg::*;

  localparam int NW   = (PAGE_CAPACITY + WORD_W - 1) / WORD_W;
  localparam int IW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW0  = ($clog2(NW * WORD_W) + 1 > REQ_W) ? $clog2(NW * WORD_W) + 1 : REQ_W;
  localparam int CW   = CW0 + 1;
  localparam logic [IW-1:0] LAST_W = IW'(NW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // configuration
  logic [BASE_W-1:0]  base_r;
  logic [PAGES_W-1:0] pages_r;
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pages_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3])
        CFG_BASE:  base_r  <= cfg_pwdata[BASE_W-1:0];
        CFG_PAGES: pages_r <= cfg_pwdata[PAGES_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      CFG_BASE:  cfg_prdata = {24'd0, base_r};
      CFG_PAGES: cfg_prdata = {39'd0, pages_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // header pages: floor(pages/32769)+1, via pages>>15 and one correction
  logic [9:0]  q_est, n_hdr;
  logic [25:0] q_prod;
  logic [25:0] end_full;
  logic [CW-1:0] end_lim;
  logic [PAGES_W-1:0] start_lim;
  always_comb begin
    q_est  = pages_r[PAGES_W-1:HDR_SHIFT];
    q_prod = {1'b0, q_est, 15'd0} + 26'(q_est);
    n_hdr  = q_est - ((q_prod > 26'(pages_r)) ? 10'd1 : 10'd0) + 10'd1;
    end_full = {1'b0, n_hdr, 15'd0};
    end_lim  = (end_full < 26'(PAGE_CAPACITY)) ? CW'(end_full) : CW'(PAGE_CAPACITY);
    start_lim = (pages_r >= PAGES_W'(n_hdr)) ?
                ((pages_r - PAGES_W'(n_hdr)) & ~PAGES_W'(7)) : '0;
  end

  // control
  logic [2:0]          state_r;
  logic [IW-1:0]       cnt_r;
  logic                mode_r;
  logic [REQ_W-1:0]    req_r;
  logic [REQ_W-1:0]    run_r;
  logic                found_r;
  logic [CW-1:0]       fit_r;
  logic [CW-1:0]       mlo_r, mhi_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ADDR_W-1:0]   res_addr_r;

  logic                out_free;
  logic                out_load;
  logic [WORD_W-1:0]   head_q, head_d;
  logic [REQ_W-1:0]    run_o;
  logic                hit_o;
  logic [IDX_W-1:0]    hit_idx;
  logic [CW-1:0]       base_pos;
  logic                rotate;

  wire in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign rotate    = (state_r == S_SCAN) || (state_r == S_MARK);
  assign base_pos  = CW'({cnt_r, {IDX_W{1'b0}}});
  assign out_load  = (state_r == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= '0;
            found_r <= 1'b0;
            if (in_tuser[0]) state_r <= S_MARK;
            else if (in_tdata[24:12] == '0) state_r <= S_DONE;
            else state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_o && !found_r) found_r <= 1'b1;
          cnt_r <= (cnt_r == LAST_W) ? '0 : cnt_r + 1'b1;
          if (cnt_r == LAST_W) state_r <= S_CHK;
        end
        S_CHK: begin
          if (found_r && (PAGES_W'(fit_r) < start_lim)) state_r <= S_MARK;
          else state_r <= S_DONE;
        end
        S_MARK: begin
          cnt_r <= (cnt_r == LAST_W) ? '0 : cnt_r + 1'b1;
          if (cnt_r == LAST_W) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload of the item in flight
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        mode_r <= in_tuser[0];
        req_r  <= in_tdata[24:12];
        run_r  <= '0;
        mlo_r  <= CW'(in_tdata[11:0]);
        mhi_r  <= CW'(in_tdata[11:0]) + CW'(in_tdata[24:12]);
        res_addr_r   <= '0;
        res_status_r <= (!in_tuser[0] && in_tdata[24:12] == '0) ? ST_ZERO : ST_OK;
      end
      S_SCAN: begin
        run_r <= run_o;
        if (hit_o && !found_r) fit_r <= base_pos + CW'(hit_idx) + CW'(1) - CW'(req_r);
      end
      S_CHK: begin
        mlo_r <= fit_r;
        mhi_r <= fit_r + CW'(req_r);
        if (found_r && (PAGES_W'(fit_r) < start_lim)) begin
          res_status_r <= ST_OK;
          res_addr_r   <= ADDR_W'(base_r) + ADDR_W'(n_hdr) + ADDR_W'(fit_r);
        end else begin
          res_status_r <= ST_NO_FIT;
          res_addr_r   <= '0;
        end
      end
      default: ;
    endcase
  end

  // bitmap ring: cell 0 feeds the head, head output re-enters at the far end
  logic [WORD_W-1:0] cell_q [NW];
  genvar g;
  generate
    for (g = 0; g < NW; g++) begin : g_cell
      bffa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (rotate),
        .d_i      ((g == NW - 1) ? head_d : cell_q[(g + 1) % NW]),
        .q_o      (cell_q[g])
      );
    end
  endgenerate
  assign head_q = cell_q[0];

  bffa_scan #(
    .CAP (PAGE_CAPACITY),
    .CW  (CW)
  ) u_scan (
    .word_i   (head_q),
    .base_pos (base_pos),
    .mark_en  (state_r == S_MARK),
    .mark_lo  (mlo_r),
    .mark_hi  (mhi_r),
    .scan_en  (state_r == S_SCAN),
    .run_i    (run_r),
    .req      (req_r),
    .end_lim  (end_lim),
    .word_o   (head_d),
    .run_o    (run_o),
    .hit_o    (hit_o),
    .hit_idx  (hit_idx)
  );

  logic [ADDR_W-1:0] out_addr;
  bffa_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .status_i (res_status_r),
    .addr_i   (mode_r ? '0 : res_addr_r),
    .ready_i  (out_tready),
    .valid_o  (out_tvalid),
    .free_o   (out_free),
    .status_o (out_tuser),
    .addr_o   (out_addr)
  );
  assign out_tdata = {7'd0, out_addr};
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the bitmap first-fit page allocator.
// Depends on rtl/bffa_pkg.sv and rtl/bitmap_first_fit_page_allocator.sv; checks every result beat.
`timescale 1ns / 1ps
module tb;
  import bffa_pkg::*;

  localparam int CAP = 4096;
  localparam int LATENCY = 300;
  localparam int LIMIT = 3000000;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_MARK = 1'b1;
  localparam logic [3:0] ADDR_BASE = 4'd0;
  localparam logic [3:0] ADDR_PAGES = 4'd8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;   // [11:0] start_page, [24:12] request_pages, rest zero
  logic [0:0] in_tuser = '0;    // [0] mode
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;       // [40:0] address_page, rest zero
  logic [1:0] out_tuser;        // [1:0] status
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  bitmap_first_fit_page_allocator #(.PAGE_CAPACITY(CAP)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  bit page_used [CAP];
  logic [BASE_W-1:0] base_page = '0;
  logic [PAGES_W-1:0] sect_pages = '0;
  alloc_result_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d address_page %0h", out_tuser, out_tdata[40:0]);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_tuser);
          errors++;
        end
        if (out_tdata[40:0] !== exp_r.addr) begin
          $error("address_page: expected %0h actual %0h", exp_r.addr, out_tdata[40:0]);
          errors++;
        end
        if (out_tdata[47:41] !== 7'd0) begin
          $error("out_tdata pad: expected 0 actual %0h", out_tdata[47:41]);
          errors++;
        end
      end
    end
  end

  function automatic alloc_result_t first_fit(logic mode, logic [11:0] start, logic [12:0] req);
    alloc_result_t r;
    longint n, start_limit, run, s;
    bit found;
    r = '0;
    if (mode == MODE_MARK) begin
      for (int i = 0; i < req; i++)
        if (start + i < CAP) page_used[start + i] = 1'b1;
      return r;
    end
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    n = longint'(sect_pages) / 32769 + 1;
    start_limit = (longint'(sect_pages) >= n) ? ((longint'(sect_pages) - n) / 8) * 8 : 0;
    run = 0;
    found = 1'b0;
    s = 0;
    for (int i = 0; i < CAP; i++) begin
      run = page_used[i] ? 0 : run + 1;
      if (run >= req) begin
        s = i + 1 - req;
        found = (s < start_limit);
        break;
      end
    end
    if (!found) begin
      r.status = ST_NO_FIT;
      return r;
    end
    for (int i = 0; i < req; i++) page_used[s + i] = 1'b1;
    r.status = ST_OK;
    r.addr = ADDR_W'(longint'(base_page) + n + s);
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(logic mode, logic [11:0] start, logic [12:0] req);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {7'd0, req, start};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(first_fit(mode, start, req));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_BASE) base_page = value[BASE_W-1:0];
    else sect_pages = value[PAGES_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_section(logic [BASE_W-1:0] base, logic [PAGES_W-1:0] pages);
    drain();
    write_reg(ADDR_BASE, 64'(base));
    write_reg(ADDR_PAGES, 64'(pages));
  endtask

  task automatic test_directed();
    set_section('0, 25'd100);
    send_request(MODE_ALLOC, 12'hFFF, 13'd0);      // zero allocate
    send_request(MODE_ALLOC, 12'd0, 13'd1);
    send_request(MODE_ALLOC, 12'd0, 13'd8);
    send_request(MODE_MARK, 12'd50, 13'd3);
    send_request(MODE_ALLOC, 12'd0, 13'd45);       // must skip the marked run
    send_request(MODE_ALLOC, 12'd0, 13'd4096);     // as long as the whole map
    send_request(MODE_MARK, 12'd7, 13'd0);         // zero mark
    send_request(MODE_MARK, 12'hFFF, 13'd4096);    // mostly beyond capacity
    send_request(MODE_ALLOC, 12'd0, 13'd100);      // crosses start limit
    send_request(MODE_ALLOC, 12'd0, 13'd40);
    set_section('0, '0);                           // tiny section
    send_request(MODE_ALLOC, 12'd0, 13'd1);
    set_section('0, 25'd1);
    send_request(MODE_ALLOC, 12'd0, 13'd1);
    set_section({BASE_W{1'b1}}, 25'd16777216);
    send_request(MODE_ALLOC, 12'd0, 13'd1);
    send_request(MODE_ALLOC, 12'hAAA, 13'h0AAA);
    send_request(MODE_ALLOC, 12'h555, 13'd3);
    set_section(40'h5555555555, 25'd65538);
    send_request(MODE_ALLOC, 12'd0, 13'd2);
    send_request(MODE_MARK, 12'h555, 13'h1555);
  endtask

  task automatic random_items(int count);
    int pick;
    logic [12:0] req;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        req = (pick < 2) ? 13'd0 : 13'($urandom_range(1, 5));
        send_request(MODE_ALLOC, 12'($urandom), req);
      end else if (pick < 96) begin
        send_request(MODE_MARK, 12'($urandom), 13'($urandom_range(0, 3)));
      end else begin
        send_request(MODE_ALLOC, 12'($urandom), 13'($urandom));   // noise
      end
      if (k == count / 2 && count > 50) drain();   // pause until every result is in
    end
  endtask

  task automatic test_random();
    int pace [4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{25, 25}};
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_section('0, 25'd16777216);
        1: set_section(40'($urandom) | (40'($urandom) << 32), 25'd3000);
        2: set_section({BASE_W{1'b1}}, 25'($urandom_range(0, 16777216)));
        3: set_section('0, 25'd20);
        4: set_section(40'd12345, 25'd32768 * 3 + 25'd7);
        default: set_section({BASE_W{1'b1}}, 25'd16777216);
      endcase
      send_idle_pct = pace[ph % 4][0];
      stall_pct = pace[ph % 4][1];
      random_items(105);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    drain();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
